[sv/y2r_pkg.sv]
// Shared types, constants and arithmetic helpers for the YUYV to RGB converter.
// No dependencies.
package y2r_pkg;

	localparam int GAIN_W = 10;
	localparam int PIX_W  = 8;
	localparam int PROD_W = 19;
	localparam int SUM_W  = 21;

	localparam logic [GAIN_W-1:0] RED_CR_RST   = 10'd359;
	localparam logic [GAIN_W-1:0] GREEN_CB_RST = 10'd88;
	localparam logic [GAIN_W-1:0] GREEN_CR_RST = 10'd183;
	localparam logic [GAIN_W-1:0] BLUE_CB_RST  = 10'd454;
	localparam logic [PIX_W-1:0]  PIX_MAX      = 8'd255;

	typedef enum logic [1:0] {
		REG_RED_CR   = 2'd0,
		REG_GREEN_CB = 2'd1,
		REG_GREEN_CR = 2'd2,
		REG_BLUE_CB  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] red_cr;
		logic [GAIN_W-1:0] green_cb;
		logic [GAIN_W-1:0] green_cr;
		logic [GAIN_W-1:0] blue_cb;
	} gains_t;

	// chroma products, shared by both pixel lanes
	typedef struct packed {
		logic signed [PROD_W-1:0] red_cr;
		logic signed [PROD_W-1:0] green_cb;
		logic signed [PROD_W-1:0] green_cr;
		logic signed [PROD_W-1:0] blue_cb;
	} prod_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_t;

	// offset binary chroma byte times unsigned gain
	function automatic logic signed [PROD_W-1:0] mul_gain(input logic [PIX_W-1:0] c,
			input logic [GAIN_W-1:0] g);
		logic signed [PROD_W-1:0] cs;
		logic signed [PROD_W-1:0] gs;
		cs = $signed({{(PROD_W-PIX_W+1){~c[PIX_W-1]}}, c[PIX_W-2:0]});
		gs = $signed({{(PROD_W-GAIN_W){1'b0}}, g});
		return cs * gs;
	endfunction

	function automatic logic signed [SUM_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
		return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	// floor divide by 256, saturate to 0..255
	function automatic logic [PIX_W-1:0] sat_pix(input logic signed [SUM_W-1:0] s);
		logic [PIX_W-1:0] r;
		if (s[SUM_W-1])
			r = '0;
		else if (s[SUM_W-2:2*PIX_W] != '0)
			r = PIX_MAX;
		else
			r = s[2*PIX_W-1:PIX_W];
		return r;
	endfunction

endpackage

[sv/yuyv_to_rgb_converter.sv]
// Top level of the YUYV 4:2:2 to RGB converter: gain registers, handshake, output merge.
// Depends on y2r_pkg, y2r_chroma, y2r_lane.
//
// Converts one YUYV macropixel per clock into two RGB pixels. Throughput is one
// request per cycle. A request is caught in the chroma multiplier register at the
// edge that accepts it. Its result loads into the output register when stage 1 can
// move on, and is held there with m_tvalid high until the output takes it.
// Both pixel lanes share the chroma products. Back-pressure on the output stalls
// the pipeline. Input is taken whenever stage 1 is empty or can move on.
module yuyv_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // luma_first, chroma_blue, luma_second, chroma_red
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // red_first, green_first, blue_first,
	                               // red_second, green_second, blue_second
);

	y2r_pkg::gains_t gains_q;
	y2r_pkg::prod_t  prod;
	y2r_pkg::rgb_t   rgb_first;
	y2r_pkg::rgb_t   rgb_second;

	logic       valid_s1;
	logic [7:0] luma_first_s1;
	logic [7:0] luma_second_s1;
	logic       out_valid_s2;
	logic [47:0] out_data_s2;
	logic       ready_s1;
	logic       take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.red_cr   <= y2r_pkg::RED_CR_RST;
			gains_q.green_cb <= y2r_pkg::GREEN_CB_RST;
			gains_q.green_cr <= y2r_pkg::GREEN_CR_RST;
			gains_q.blue_cb  <= y2r_pkg::BLUE_CB_RST;
		end else if (cfg_we) begin
			unique case (y2r_pkg::reg_idx_t'(cfg_addr))
				y2r_pkg::REG_RED_CR:   gains_q.red_cr   <= cfg_wdata;
				y2r_pkg::REG_GREEN_CB: gains_q.green_cb <= cfg_wdata;
				y2r_pkg::REG_GREEN_CR: gains_q.green_cr <= cfg_wdata;
				y2r_pkg::REG_BLUE_CB:  gains_q.blue_cb  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign ready_s1 = !out_valid_s2 || m_tready;
	assign s_tready = !valid_s1 || ready_s1;
	assign take     = s_tvalid && s_tready;

	y2r_chroma u_chroma (
		.clk         (clk),
		.en          (take),
		.chroma_blue (s_tdata[15:8]),
		.chroma_red  (s_tdata[31:24]),
		.gains       (gains_q),
		.prod        (prod)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			luma_first_s1  <= s_tdata[7:0];
			luma_second_s1 <= s_tdata[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	y2r_lane u_lane_first (
		.luma (luma_first_s1),
		.prod (prod),
		.rgb  (rgb_first)
	);

	y2r_lane u_lane_second (
		.luma (luma_second_s1),
		.prod (prod),
		.rgb  (rgb_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (ready_s1)
			out_valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1)
			out_data_s2 <= {rgb_second, rgb_first};
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_data_s2;

`ifndef NO_ASSERTIONS
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted request did not reach stage 1");

	a_s1_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s1 |=> out_valid_s2)
		else $error("stage 1 request lost on the way out");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_s2 && !m_tready |-> !s_tready)
		else $error("input taken while pipeline is full");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(luma_first_s1) && $stable(prod))
		else $error("stage 1 changed under stall");
`endif

endmodule

[sv/y2r_chroma.sv]
// Chroma multiplier stage: registers the four chroma-times-gain products.
// Depends on y2r_pkg.
module y2r_chroma (
	input  logic                       clk,
	input  logic                       en,
	input  logic [y2r_pkg::PIX_W-1:0]  chroma_blue,
	input  logic [y2r_pkg::PIX_W-1:0]  chroma_red,
	input  y2r_pkg::gains_t            gains,
	output y2r_pkg::prod_t             prod
);

	y2r_pkg::prod_t prod_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.red_cr   <= y2r_pkg::mul_gain(chroma_red, gains.red_cr);
			prod_s1.green_cb <= y2r_pkg::mul_gain(chroma_blue, gains.green_cb);
			prod_s1.green_cr <= y2r_pkg::mul_gain(chroma_red, gains.green_cr);
			prod_s1.blue_cb  <= y2r_pkg::mul_gain(chroma_blue, gains.blue_cb);
		end
	end

	assign prod = prod_s1;

endmodule

[sv/y2r_lane.sv]
// Pixel lane: adds the chroma terms to scaled luma (green subtracts them) and saturates each channel.
// Depends on y2r_pkg.
module y2r_lane (
	input  logic [y2r_pkg::PIX_W-1:0] luma,
	input  y2r_pkg::prod_t            prod,
	output y2r_pkg::rgb_t             rgb
);

	logic signed [y2r_pkg::SUM_W-1:0] luma_w;
	logic signed [y2r_pkg::SUM_W-1:0] sum_r;
	logic signed [y2r_pkg::SUM_W-1:0] sum_g;
	logic signed [y2r_pkg::SUM_W-1:0] sum_b;

	assign luma_w = $signed({{(y2r_pkg::SUM_W-2*y2r_pkg::PIX_W){1'b0}}, luma,
		{y2r_pkg::PIX_W{1'b0}}});

	assign sum_r = luma_w + y2r_pkg::ext_prod(prod.red_cr);
	assign sum_g = luma_w - y2r_pkg::ext_prod(prod.green_cb) - y2r_pkg::ext_prod(prod.green_cr);
	assign sum_b = luma_w + y2r_pkg::ext_prod(prod.blue_cb);

	assign rgb.red   = y2r_pkg::sat_pix(sum_r);
	assign rgb.green = y2r_pkg::sat_pix(sum_g);
	assign rgb.blue  = y2r_pkg::sat_pix(sum_b);

endmodule
